// File: rtl/core/cke_pkg.sv
`default_nettype none

package cke_pkg;

  // Debounce depth in samples and number of chord buttons.
  localparam int unsigned STABLE_SAMPLES = 8;
  localparam int unsigned BUTTON_COUNT   = 5;

  localparam int unsigned CODE_W = 7;

  typedef logic [STABLE_SAMPLES-1:0] hist_t;
  typedef logic [BUTTON_COUNT-1:0]   chord_t;
  typedef logic [CODE_W-1:0]         code_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_BS   = 2'd1,
    KIND_CR   = 2'd2,
    KIND_NONE = 2'd3
  } key_kind_e;

  // Table markers for the non-printing entries.
  localparam code_t CODE_UNMAPPED = 7'h00;
  localparam code_t CODE_BS       = 7'h08;
  localparam code_t CODE_CR       = 7'h0D;

  // Chord to key, indexed by the chord (bit4 thumb .. bit0 pinkie).
  localparam code_t KEY_TABLE [32] = '{
    CODE_UNMAPPED, 7'h75, 7'h6F, 7'h73, 7'h69, 7'h7A, 7'h6C, CODE_UNMAPPED,
    7'h65, 7'h62, 7'h6D, 7'h78, 7'h74, 7'h71, CODE_BS, 7'h68,
    7'h61, 7'h79, 7'h6B, CODE_CR, 7'h64, 7'h77, 7'h67, 7'h63,
    7'h6E, 7'h70, 7'h66, 7'h76, CODE_UNMAPPED, 7'h6A, 7'h72, 7'h20
  };

  // Completed chord from the debounce stage.
  typedef struct packed {
    logic   fire;
    chord_t chord;
  } chord_evt_t;

endpackage

`default_nettype wire

// File: rtl/core/cke_debounce.sv
`default_nettype none

module cke_debounce
  import cke_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   step_i,    // process one tick
  input  wire chord_t levels_i,  // active low
  output chord_evt_t  evt_o
);

  hist_t  hist_q [BUTTON_COUNT];
  hist_t  hist_d [BUTTON_COUNT];
  chord_t marks_q, marks_d, marks_upd;
  logic   any_held_q, any_held_d, any_held_upd;
  logic   all_rel;

  always_comb begin
    marks_upd = marks_q;
    all_rel   = 1'b1;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      hist_d[i] = {hist_q[i][STABLE_SAMPLES-2:0], levels_i[i]};
      if (hist_d[i] == '0) marks_upd[i] = 1'b1;
      if (hist_d[i] != '1) all_rel = 1'b0;
    end
    any_held_upd = any_held_q | (marks_upd != '0);
  end

  always_comb begin
    evt_o.fire  = step_i & any_held_upd & all_rel;
    evt_o.chord = marks_upd;
    marks_d     = marks_q;
    any_held_d  = any_held_q;
    if (step_i) begin
      marks_d    = evt_o.fire ? '0 : marks_upd;
      any_held_d = evt_o.fire ? 1'b0 : any_held_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) hist_q[i] <= '0;
      marks_q    <= '0;
      any_held_q <= 1'b0;
    end else begin
      if (step_i) begin
        for (int i = 0; i < BUTTON_COUNT; i++) hist_q[i] <= hist_d[i];
      end
      marks_q    <= marks_d;
      any_held_q <= any_held_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cke_decode.sv
`default_nettype none

module cke_decode
  import cke_pkg::*;
(
  input  wire chord_t chord_i,
  output key_kind_e   kind_o,
  output code_t       code_o
);

  code_t raw;

  assign raw = KEY_TABLE[chord_i];

  always_comb begin
    kind_o = KIND_CHAR;
    code_o = raw;
    unique case (raw)
      CODE_UNMAPPED: begin
        kind_o = KIND_NONE;
        code_o = '0;
      end
      CODE_BS: begin
        kind_o = KIND_BS;
        code_o = '0;
      end
      CODE_CR: begin
        kind_o = KIND_CR;
        code_o = '0;
      end
      default: begin
        kind_o = KIND_CHAR;
        code_o = raw;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/chord_keyboard_encoder_top.sv
`default_nettype none

// Five-button chord encoder. Each input request is one sample tick: the
// raw active-low pin levels plus a link-up flag (ticks with the flag low are
// taken and ignored). Every button is shifted into its own 8-sample history;
// a button counts as held once its history is all zeros, and that mark sticks.
// When some button has been held and all histories read all ones (every
// button released), one result request goes out with the chord and the key
// decoded from a fixed table: a letter or space (kind 0, ASCII in char_code),
// backspace (1), return (2) or unmapped (3); char_code is 0 for kinds 1-3.
// Rate: one tick per clock cycle sustained while results are taken as they
// appear. An accepted tick passes the input register and then the result
// register; the debounce update and table lookup sit between them. A tick
// leaves the input register only when the result register is empty or being
// taken, so while a result waits one more tick parks in the input register
// and then the input side stalls until the result is taken. After reset the
// histories read all zeros, so a button seen pressed on the first tick is
// held at once.

module chord_keyboard_encoder_top
  import cke_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [4:0] raw_levels, [5] link_up
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o,   // [4:0] chord, [11:5] char_code
  output      logic [1:0]  m_axis_tuser_o    // [1:0] key_kind
);

  // input register
  logic   in_vld_q;
  chord_t in_lvl_q;
  logic   in_link_q;
  logic   adv;            // input register moves into the result side

  // result register
  logic      out_vld_q, out_vld_d;
  chord_t    out_chord_q;
  key_kind_e out_kind_q;
  code_t     out_code_q;

  chord_evt_t evt;
  key_kind_e  dec_kind;
  code_t      dec_code;

  assign adv             = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_lvl_q  <= s_axis_tdata_i[BUTTON_COUNT-1:0];
      in_link_q <= s_axis_tdata_i[BUTTON_COUNT];
    end
  end

  cke_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv & in_link_q),
    .levels_i (in_lvl_q),
    .evt_o    (evt)
  );

  cke_decode u_decode (
    .chord_i (evt.chord),
    .kind_o  (dec_kind),
    .code_o  (dec_code)
  );

  // a taken result clears the slot unless a new chord lands in the same cycle
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = evt.fire;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.fire) begin
      out_chord_q <= evt.chord;
      out_kind_q  <= dec_kind;
      out_code_q  <= dec_code;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_code_q, out_chord_q};
  assign m_axis_tuser_o  = out_kind_q;

  // a new result only ever follows a tick that moved out of the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv))
    else $error("result appeared without an advancing tick");

  // a sent chord always has at least one held button
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_chord_q != '0))
    else $error("empty chord sent");

  // char_code is nonzero exactly for character results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_kind_q == KIND_CHAR) == (out_code_q != '0)))
    else $error("char_code does not match key_kind");

  // the input side stalls only behind a full input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q && !m_axis_tready_i))
    else $error("input stalled without cause");

endmodule

`default_nettype wire
